// ===== hw/rtl/cfd_pkg.sv =====
// Shared types and constants for the CRC-checked frame deframer.
package cfd_pkg;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_LEN0 = 3'd1,
		PH_LEN1 = 3'd2,
		PH_DATA = 3'd3,
		PH_CRC0 = 3'd4,
		PH_CRC1 = 3'd5,
		PH_DONE = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_END  = 2'd1,
		ST_FAIL = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RF_IDLE  = 2'd0,
		RF_STEP0 = 2'd1,
		RF_STEP1 = 2'd2
	} refresh_t;

	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MARKER_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CRC_SEED      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BUF_CAP       = 3'd5;

	typedef struct packed {
		status_t     status;
		logic        payload_valid;
		logic [7:0]  payload_byte;
		logic [9:0]  payload_index;
		logic [10:0] frame_length;
	} result_t;

endpackage

// ===== hw/rtl/cfd_if.sv =====
// Handshake channel interfaces for the deframer: byte input, result output, register writes.
interface cfd_byte_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte;

	modport source (output valid, output action, output rx_byte, input ready);
	modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface cfd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        payload_valid;
	logic [7:0]  payload_byte;
	logic [9:0]  payload_index;
	logic [10:0] frame_length;

	modport source (output valid, output status, output payload_valid, output payload_byte,
		output payload_index, output frame_length, input ready);
	modport sink (input valid, input status, input payload_valid, input payload_byte,
		input payload_index, input frame_length, output ready);
endinterface

interface cfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/cfd_crc_byte.sv =====
// One byte of an MSB-first CRC-16 with a programmable polynomial.
module cfd_crc_byte (
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	input  logic [15:0] poly,
	output logic [15:0] crc_out
);
	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ poly;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end
endmodule

// ===== hw/rtl/crc_checked_frame_deframer.sv =====
// Top level of the CRC-checked frame deframer: header hunt, length, payload and CRC check.
//
//  channel | direction | payload                                   | accepted when
//  bytes   | in        | action, rx_byte                           | valid && ready
//  results | out       | status, payload_valid, payload_byte,      | valid && ready
//          |           | payload_index, frame_length               |
//  cfg     | in        | index (register number), data             | valid && ready
//
// One byte per cycle while no refresh runs and the skid register is empty; each result is
// registered in the result register, or in a skid register when the result side stalls.
// After reset and each register write the block works out the CRC of the two header
// markers in RF_STEP0 and RF_STEP1 and takes no byte then; register writes are always taken.
// Reset is asynchronous and returns the decoder to the header hunt with the default registers.
module crc_checked_frame_deframer #(
	parameter int unsigned PAYLOAD_MAX = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	cfd_byte_if.sink     bytes,
	cfd_result_if.source results,
	cfd_cfg_if.sink      cfg
);
	import cfd_pkg::*;

	localparam logic [15:0] PayloadMaxW = 16'(PAYLOAD_MAX);

	// Registers.
	logic [7:0]  marker_first_q, marker_second_q;
	logic [15:0] crc_poly_q, crc_seed_q;
	logic [10:0] max_len_q, buf_cap_q;

	// Decoder state.
	phase_t      phase_q, phase_n;
	logic [15:0] last_two_q, last_two_n;
	logic [15:0] crc_q, crc_n;
	logic [10:0] expected_q, expected_n;
	logic [10:0] filled_q, filled_n;

	// CRC after both markers, from the current shifter and from the seed.
	logic [15:0] mk_crc_q, mk_crc_n, mk_seed_q;
	logic [15:0] tmp_cur_q, tmp_seed_q;
	refresh_t    rf_q, rf_n;

	logic [15:0] feed_main, feed_a, feed_b;
	logic [15:0] ra_crc, rb_crc;
	logic [7:0]  r_byte;
	logic        cfg_fire, in_fire, out_fire;
	logic        rst_decoder;
	result_t     res_n, res_q, skid_q;
	logic        res_valid_q, skid_valid_q;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;
	assign bytes.ready = (rf_q == RF_IDLE) & ~skid_valid_q;
	assign in_fire   = bytes.valid & bytes.ready;
	assign out_fire  = res_valid_q & results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_first_q  <= 8'h55;
			marker_second_q <= 8'hAA;
			crc_poly_q      <= 16'h1021;
			crc_seed_q      <= 16'hFFFF;
			max_len_q       <= 11'd1024;
			buf_cap_q       <= 11'd1024;
		end else if (cfg_fire) begin
			case (cfg.index)
				REG_MARKER_FIRST:  marker_first_q  <= cfg.data[7:0];
				REG_MARKER_SECOND: marker_second_q <= cfg.data[7:0];
				REG_CRC_POLY:      crc_poly_q      <= cfg.data;
				REG_CRC_SEED:      crc_seed_q      <= cfg.data;
				REG_MAX_LEN:       max_len_q       <= cfg.data[10:0];
				REG_BUF_CAP:       buf_cap_q       <= cfg.data[10:0];
				default: ;
			endcase
		end
	end

	// Marker CRC refresh: first marker in the first step, second marker in the next.
	assign r_byte = (rf_q == RF_STEP0) ? marker_first_q : marker_second_q;
	assign ra_crc = (rf_q == RF_STEP0) ? crc_q : tmp_cur_q;
	assign rb_crc = (rf_q == RF_STEP0) ? crc_seed_q : tmp_seed_q;

	cfd_crc_byte u_feed_cur (.crc_in(ra_crc), .data(r_byte), .poly(crc_poly_q), .crc_out(feed_a));
	cfd_crc_byte u_feed_seed (.crc_in(rb_crc), .data(r_byte), .poly(crc_poly_q), .crc_out(feed_b));
	cfd_crc_byte u_feed_main (.crc_in(crc_q), .data(bytes.rx_byte), .poly(crc_poly_q),
		.crc_out(feed_main));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q <= RF_STEP0;
		end else begin
			rf_q <= rf_n;
		end
	end

	always_comb begin
		rf_n = rf_q;
		case (rf_q)
			RF_IDLE:  rf_n = RF_IDLE;
			RF_STEP0: rf_n = RF_STEP1;
			RF_STEP1: rf_n = RF_IDLE;
			default:  rf_n = RF_IDLE;
		endcase
		if (cfg_fire) begin
			rf_n = RF_STEP0;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_q == RF_STEP0) begin
			tmp_cur_q  <= feed_a;
			tmp_seed_q <= feed_b;
		end
		if (rf_q == RF_STEP1) begin
			mk_seed_q <= feed_b;
		end
	end

	// Decoder next state and result for the byte at the input.
	always_comb begin
		phase_n     = phase_q;
		last_two_n  = last_two_q;
		crc_n       = crc_q;
		mk_crc_n    = mk_crc_q;
		expected_n  = expected_q;
		filled_n    = filled_q;
		rst_decoder = 1'b0;
		res_n       = '0;
		res_n.status = ST_OK;

		if (bytes.action) begin
			rst_decoder = 1'b1;
		end else if (filled_q == buf_cap_q) begin
			res_n.status = ST_FULL;
		end else begin
			case (phase_q)
				PH_HUNT: begin
					last_two_n = {bytes.rx_byte, last_two_q[15:8]};
					if (last_two_n[7:0] == marker_first_q &&
						last_two_n[15:8] == marker_second_q) begin
						crc_n   = mk_crc_q;
						phase_n = PH_LEN0;
					end
				end
				PH_LEN0: begin
					last_two_n = {bytes.rx_byte, last_two_q[15:8]};
					crc_n      = feed_main;
					phase_n    = PH_LEN1;
				end
				PH_LEN1: begin
					last_two_n = {bytes.rx_byte, last_two_q[15:8]};
					crc_n      = feed_main;
					if (last_two_n == 16'd0) begin
						expected_n = 11'd0;
						phase_n    = PH_CRC0;
					end else if (last_two_n > {5'd0, max_len_q} || last_two_n > PayloadMaxW) begin
						rst_decoder = 1'b1;
					end else begin
						expected_n = last_two_n[10:0];
						phase_n    = PH_DATA;
					end
				end
				PH_DATA: begin
					crc_n                = feed_main;
					res_n.payload_valid  = 1'b1;
					res_n.payload_byte   = bytes.rx_byte;
					res_n.payload_index  = filled_q[9:0];
					filled_n             = filled_q + 11'd1;
					if (filled_n == expected_q) begin
						phase_n = PH_CRC0;
					end
				end
				PH_CRC0: begin
					crc_n   = feed_main;
					phase_n = PH_CRC1;
				end
				PH_CRC1: begin
					crc_n = feed_main;
					if (feed_main != 16'd0) begin
						res_n.status = ST_FAIL;
					end else begin
						phase_n = PH_DONE;
					end
				end
				default: ;
			endcase
			if (res_n.status == ST_OK && phase_n == PH_DONE) begin
				res_n.status = ST_END;
			end
		end

		if (rst_decoder) begin
			phase_n    = PH_HUNT;
			last_two_n = 16'd0;
			crc_n      = crc_seed_q;
			mk_crc_n   = mk_seed_q;
			expected_n = 11'd0;
			filled_n   = 11'd0;
		end
		res_n.frame_length = expected_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			last_two_q <= 16'd0;
			crc_q      <= 16'hFFFF;
			expected_q <= 11'd0;
			filled_q   <= 11'd0;
		end else if (in_fire) begin
			phase_q    <= phase_n;
			last_two_q <= last_two_n;
			crc_q      <= crc_n;
			expected_q <= expected_n;
			filled_q   <= filled_n;
		end
	end

	// The shifter only changes outside a refresh; there the marker CRC is reloaded on a decoder restart.
	always_ff @(posedge clk) begin
		if (rf_q == RF_STEP1) begin
			mk_crc_q <= feed_a;
		end else if (in_fire) begin
			mk_crc_q <= mk_crc_n;
		end
	end

	// Result register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!res_valid_q || out_fire) begin
				res_valid_q  <= in_fire | skid_valid_q;
				skid_valid_q <= 1'b0;
			end else if (in_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!res_valid_q || out_fire) begin
			res_q <= skid_valid_q ? skid_q : res_n;
		end else if (in_fire) begin
			skid_q <= res_n;
		end
	end

	assign results.valid         = res_valid_q;
	assign results.status        = res_q.status;
	assign results.payload_valid = res_q.payload_valid;
	assign results.payload_byte  = res_q.payload_byte;
	assign results.payload_index = res_q.payload_index;
	assign results.frame_length  = res_q.frame_length;

	a_no_byte_after_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_fire |=> !in_fire)
		else $error("byte accepted right after a register write");

	a_skid_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> res_valid_q)
		else $error("skid entry held while result register is empty");

	a_data_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> expected_q != 11'd0)
		else $error("payload phase with zero expected length");

	a_payload_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.payload_valid) |-> res_q.status == ST_OK)
		else $error("payload item with a status other than success");

endmodule

// ===== sim/deframer_result_checker.sv =====
// Watches the deframer channels, predicts each result and compares it with what the block returns.
`timescale 1ns / 1ps

module deframer_result_checker #(
	parameter int unsigned PAYLOAD_MAX = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_ready,
	input  logic        byte_action,
	input  logic [7:0]  byte_data,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [1:0]  res_status,
	input  logic        res_payload_valid,
	input  logic [7:0]  res_payload_byte,
	input  logic [9:0]  res_payload_index,
	input  logic [10:0] res_frame_length,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);
	import cfd_pkg::*;

	logic [7:0]  mk_first;
	logic [7:0]  mk_second;
	logic [15:0] poly;
	logic [15:0] seed;
	logic [10:0] max_len;
	logic [10:0] capacity;

	phase_t      ph;
	logic [15:0] window;
	logic [15:0] crc;
	logic [10:0] exp_len;
	logic [10:0] filled;

	result_t expected_results[$];
	int      mismatch_count;

	assign mismatches = mismatch_count;

	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		repeat (8) r = r[15] ? ((r << 1) ^ poly) : (r << 1);
		return r;
	endfunction

	task automatic restart_decoder();
		ph = PH_HUNT;
		window = '0;
		crc = seed;
		exp_len = '0;
		filled = '0;
	endtask

	task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
		case (idx)
			REG_MARKER_FIRST: mk_first = val[7:0];
			REG_MARKER_SECOND: mk_second = val[7:0];
			REG_CRC_POLY: poly = val;
			REG_CRC_SEED: seed = val;
			REG_MAX_LEN: max_len = val[10:0];
			REG_BUF_CAP: capacity = val[10:0];
			default: ;
		endcase
	endtask

	task automatic deframe_byte(input logic act, input logic [7:0] b);
		result_t r;
		r.status = ST_OK;
		r.payload_valid = 1'b0;
		r.payload_byte = '0;
		r.payload_index = '0;
		if (act) begin
			restart_decoder();
		end else if (filled == capacity) begin
			r.status = ST_FULL;
		end else begin
			case (ph)
				PH_HUNT: begin
					window = {b, window[15:8]};
					// The older byte sits in the low half of the window.
					if (window[7:0] == mk_first && window[15:8] == mk_second) begin
						crc = crc_update(crc_update(crc, window[7:0]), window[15:8]);
						ph = PH_LEN0;
					end
				end
				PH_LEN0: begin
					window = {b, window[15:8]};
					crc = crc_update(crc, b);
					ph = PH_LEN1;
				end
				PH_LEN1: begin
					window = {b, window[15:8]};
					crc = crc_update(crc, b);
					if (window == 16'd0) begin
						exp_len = '0;
						ph = PH_CRC0;
					end else if (window > max_len || window > PAYLOAD_MAX) begin
						restart_decoder();
					end else begin
						exp_len = window[10:0];
						ph = PH_DATA;
					end
				end
				PH_DATA: begin
					crc = crc_update(crc, b);
					r.payload_valid = 1'b1;
					r.payload_byte = b;
					r.payload_index = filled[9:0];
					filled = filled + 11'd1;
					if (filled == exp_len) ph = PH_CRC0;
				end
				PH_CRC0: begin
					crc = crc_update(crc, b);
					ph = PH_CRC1;
				end
				PH_CRC1: begin
					// After a mismatch the decoder stays here and keeps feeding the CRC.
					crc = crc_update(crc, b);
					if (crc != 16'd0) r.status = ST_FAIL;
					else ph = PH_DONE;
				end
				default: ;
			endcase
			if (r.status == ST_OK && ph == PH_DONE) r.status = ST_END;
		end
		r.frame_length = exp_len;
		expected_results.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t got;
		if (!arst_n) begin
			mk_first = 8'h55;
			mk_second = 8'hAA;
			poly = 16'h1021;
			seed = 16'hFFFF;
			max_len = 11'd1024;
			capacity = 11'd1024;
			restart_decoder();
			expected_results.delete();
			mismatch_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
			if (byte_valid && byte_ready) deframe_byte(byte_action, byte_data);
			if (res_valid && res_ready) begin
				got = {res_status, res_payload_valid, res_payload_byte, res_payload_index,
					res_frame_length};
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected result: status %0d pv %0d byte %0d idx %0d len %0d",
							$time, res_status, res_payload_valid, res_payload_byte,
							res_payload_index, res_frame_length);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: result mismatch: expected status %0d pv %0d byte %0d ",
								"idx %0d len %0d, got status %0d pv %0d byte %0d idx %0d len %0d"},
								$time, want.status, want.payload_valid, want.payload_byte,
								want.payload_index, want.frame_length, res_status,
								res_payload_valid, res_payload_byte, res_payload_index,
								res_frame_length);
					end
				end
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== sim/crc_checked_frame_deframer_tb.sv =====
// Stimulus and verdict for the CRC-checked frame deframer, with the result checker beside it.
`timescale 1ns / 1ps

module crc_checked_frame_deframer_tb;
	import cfd_pkg::*;

	localparam int unsigned PAYLOAD_MAX = 1024;
	localparam int HOLD_CYCLES = 80;

	logic clk;
	logic arst_n;

	cfd_byte_if   bytes_if ();
	cfd_result_if results_if ();
	cfd_cfg_if    cfg_if ();

	int mismatches;
	int outstanding;

	int items_sent;
	int src_idle_pct;
	int sink_idle_pct;
	int hold_ticket;
	int hold_served;
	int hold_left;

	logic [7:0]  cur_mf;
	logic [7:0]  cur_ms;
	logic [15:0] cur_poly;
	logic [15:0] cur_seed;
	logic [10:0] cur_max;

	crc_checked_frame_deframer #(
		.PAYLOAD_MAX(PAYLOAD_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(bytes_if),
		.results(results_if),
		.cfg(cfg_if)
	);

	deframer_result_checker #(
		.PAYLOAD_MAX(PAYLOAD_MAX)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(bytes_if.valid),
		.byte_ready(bytes_if.ready),
		.byte_action(bytes_if.action),
		.byte_data(bytes_if.rx_byte),
		.res_valid(results_if.valid),
		.res_ready(results_if.ready),
		.res_status(results_if.status),
		.res_payload_valid(results_if.payload_valid),
		.res_payload_byte(results_if.payload_byte),
		.res_payload_index(results_if.payload_index),
		.res_frame_length(results_if.frame_length),
		.cfg_valid(cfg_if.valid),
		.cfg_ready(cfg_if.ready),
		.cfg_index(cfg_if.index),
		.cfg_data(cfg_if.data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	// Result side: random stalls, plus one long hold-off when the stimulus asks for it.
	initial begin
		results_if.ready = 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_ticket != hold_served) begin
				hold_served = hold_ticket;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		repeat (8) r = r[15] ? ((r << 1) ^ cur_poly) : (r << 1);
		return r;
	endfunction

	task automatic send_byte(input logic act, input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			bytes_if.valid <= 1'b0;
			@(posedge clk);
		end
		bytes_if.valid <= 1'b1;
		bytes_if.action <= act;
		bytes_if.rx_byte <= b;
		@(posedge clk);
		while (!bytes_if.ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic wait_for_quiet();
		bytes_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
	endtask

	task automatic program_regs(input logic [7:0] mf, input logic [7:0] ms,
		input logic [15:0] poly, input logic [15:0] seed,
		input logic [10:0] max_len, input logic [10:0] cap);
		wait_for_quiet();
		write_reg(REG_MARKER_FIRST, {8'h00, mf});
		write_reg(REG_MARKER_SECOND, {8'h00, ms});
		write_reg(REG_CRC_POLY, poly);
		write_reg(REG_CRC_SEED, seed);
		write_reg(REG_MAX_LEN, {5'd0, max_len});
		write_reg(REG_BUF_CAP, {5'd0, cap});
		cfg_if.valid <= 1'b0;
		cur_mf = mf;
		cur_ms = ms;
		cur_poly = poly;
		cur_seed = seed;
		cur_max = max_len;
	endtask

	// Restart, marker, length, payload and CRC if it fits; truncate cuts, noisy adds stray bytes.
	task automatic send_frame(input logic [15:0] len, input bit bad_crc, input bit truncate,
		input bit noisy);
		logic [7:0]  fb[$];
		logic [15:0] c;
		int          cut;
		fb = {};
		fb.push_back(cur_mf);
		fb.push_back(cur_ms);
		fb.push_back(len[7:0]);
		fb.push_back(len[15:8]);
		if (len <= cur_max && len <= PAYLOAD_MAX) begin
			repeat (len) fb.push_back(8'($urandom));
			c = cur_seed;
			foreach (fb[i]) c = crc_update(c, fb[i]);
			if (bad_crc) c ^= 16'($urandom_range(1, 65535));
			fb.push_back(c[15:8]);
			fb.push_back(c[7:0]);
		end
		cut = truncate ? $urandom_range(1, fb.size() - 1) : fb.size();
		send_byte(1'b1, 8'($urandom));
		if (noisy) repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom));
		foreach (fb[i]) if (i < cut) send_byte(1'b0, fb[i]);
		if (noisy) repeat ($urandom_range(0, 2)) send_byte(1'b0, 8'($urandom));
	endtask

	function automatic logic [15:0] pick_length();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) return 16'($urandom_range(0, (cur_max < 12) ? int'(cur_max) : 12));
		else if (sel < 80) return (cur_max <= 64) ? 16'(cur_max) : 16'($urandom_range(0, 3));
		else if (sel < 92) return 16'(cur_max) + 16'($urandom_range(1, 3));
		else return 16'($urandom);
	endfunction

	task automatic random_phase(input int target, input bit calm, input bit squeeze);
		int stop;
		int sel;
		program_regs(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
			$urandom_range(1) ? 11'($urandom_range(1, 1024)) : 11'($urandom_range(1, 16)),
			$urandom_range(1) ? 11'd1024 : 11'($urandom_range(1, 16)));
		stop = items_sent + target;
		if (calm) begin
			src_idle_pct = 0;
			sink_idle_pct <= 0;
		end
		if (squeeze) hold_ticket <= hold_ticket + 1;
		while (items_sent < stop) begin
			if (calm && src_idle_pct == 0 && items_sent >= stop - target / 4) begin
				src_idle_pct = 21;
				sink_idle_pct <= 21;
			end
			sel = $urandom_range(99);
			if (sel < 75)
				send_frame(pick_length(), $urandom_range(99) < 15, 1'b0, 1'b1);
			else if (sel < 85)
				send_frame(pick_length(), 1'b0, 1'b1, 1'b1);
			else
				repeat ($urandom_range(1, 12)) send_byte($urandom_range(99) < 8, 8'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		bytes_if.valid = 1'b0;
		bytes_if.action = 1'b0;
		bytes_if.rx_byte = 8'h00;
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		items_sent = 0;
		src_idle_pct = 21;
		sink_idle_pct = 21;
		hold_ticket = 0;
		cur_mf = 8'h55;
		cur_ms = 8'hAA;
		cur_poly = 16'h1021;
		cur_seed = 16'hFFFF;
		cur_max = 11'd1024;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset registers: empty frame, a later byte after the end, one-byte frames with
		// good and bad CRC, and an oversized length.
		send_frame(16'd0, 1'b0, 1'b0, 1'b0);
		send_byte(1'b0, 8'hFF);
		send_frame(16'd1, 1'b0, 1'b0, 1'b0);
		send_frame(16'd1, 1'b1, 1'b0, 1'b0);
		send_frame(16'hFFFF, 1'b0, 1'b0, 1'b0);

		// Low extremes: a one-byte buffer refuses the CRC bytes after any payload.
		program_regs(8'h00, 8'hFF, 16'h0000, 16'h0000, 11'd1, 11'd1);
		repeat (8) send_frame(16'($urandom_range(0, 2)), $urandom_range(1), 1'b0, 1'b1);

		// High extremes, including one frame of the largest size. That frame runs with no
		// idling on either side, so it is also the long unbroken stretch.
		program_regs(8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 11'd1024, 11'd1024);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		send_frame(16'd1024, 1'b0, 1'b0, 1'b0);
		src_idle_pct = 21;
		sink_idle_pct = 21;
		send_frame(16'd1025, 1'b0, 1'b0, 1'b0);
		repeat (6) send_frame(16'($urandom_range(0, 8)), $urandom_range(1), 1'b0, 1'b1);

		random_phase(24, 1'b1, 1'b0);
		random_phase(24, 1'b0, 1'b1);
		random_phase(24, 1'b0, 1'b0);
		random_phase(24, 1'b0, 1'b0);
		random_phase(24, 1'b0, 1'b0);

		wait_for_quiet();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_if.sv
hw/rtl/cfd_crc_byte.sv
hw/rtl/crc_checked_frame_deframer.sv
sim/deframer_result_checker.sv
sim/crc_checked_frame_deframer_tb.sv
